/* rtl/sdci_pkg.sv */
// Shared types and constants for the SD card initialization sequencer.
// Used by sdci_step and by sd_card_init_sequencer; depends on nothing.
`default_nettype none

package sdci_pkg;

	// Event kinds presented on the input channel.
	typedef enum logic [1:0] {
		OP_START      = 2'd0,
		OP_CMD_DONE   = 2'd1,
		OP_HOST_DONE  = 2'd2,
		OP_POLL_DELAY = 2'd3
	} op_t;

	// Actions requested from the host.
	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_ISSUE_CMD = 3'd1,
		ACT_SET_FREQ  = 3'd2,
		ACT_SET_1V8   = 3'd3,
		ACT_SET_WIDTH = 3'd4,
		ACT_WAIT      = 3'd5,
		ACT_DONE      = 3'd6,
		ACT_FAILED    = 3'd7
	} action_t;

	// Failure codes reported with ACT_FAILED.
	typedef enum logic [3:0] {
		FAIL_NONE         = 4'd0,
		FAIL_CMD_ERROR    = 4'd1,
		FAIL_ECHO         = 4'd2,
		FAIL_POLL_TIMEOUT = 4'd3,
		FAIL_NOT_SDHC     = 4'd4,
		FAIL_VOLT         = 4'd5,
		FAIL_RCA_STATUS   = 4'd6,
		FAIL_NOT_READY    = 4'd7,
		FAIL_CSD_VERSION  = 4'd8
	} fail_t;

	// Sequence steps; each names the completion that the step is waiting for.
	typedef enum logic [4:0] {
		ST_IDLE     = 5'd0,
		ST_CMD0     = 5'd1,
		ST_CMD8     = 5'd2,
		ST_APP_INQ  = 5'd3,
		ST_INQ      = 5'd4,
		ST_APP_POLL = 5'd5,
		ST_POLL     = 5'd6,
		ST_WAIT     = 5'd7,
		ST_FREQ     = 5'd8,
		ST_VSW      = 5'd9,
		ST_VOLT     = 5'd10,
		ST_CID      = 5'd11,
		ST_RCA      = 5'd12,
		ST_CSD      = 5'd13,
		ST_SEL      = 5'd14,
		ST_APP_SCR  = 5'd15,
		ST_SCR      = 5'd16,
		ST_APP_BW   = 5'd17,
		ST_BW       = 5'd18,
		ST_HOST_BW  = 5'd19,
		ST_DONE     = 5'd20,
		ST_FAILED   = 5'd21
	} step_t;

	// Command indices.
	localparam logic [5:0] CMD_GO_IDLE       = 6'd0;
	localparam logic [5:0] CMD_ALL_SEND_CID  = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA      = 6'd3;
	localparam logic [5:0] ACMD_SET_BUS_WIDTH = 6'd6;
	localparam logic [5:0] CMD_SELECT        = 6'd7;
	localparam logic [5:0] CMD_SEND_IF_COND  = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD      = 6'd9;
	localparam logic [5:0] CMD_VOLT_SWITCH   = 6'd11;
	localparam logic [5:0] ACMD_SD_SEND_OP   = 6'd41;
	localparam logic [5:0] ACMD_SEND_SCR     = 6'd51;
	localparam logic [5:0] CMD_APP_CMD       = 6'd55;

	// Arguments and response checks.
	localparam logic [11:0] IF_COND_PATTERN = 12'h1AA;
	localparam logic [31:0] IF_COND_ARG     = 32'h0000_01AA;
	localparam logic [31:0] OP_COND_ARG     = 32'h41FF_8000;
	localparam logic [31:0] BUS_WIDTH_4_ARG = 32'h0000_0002;
	localparam logic [15:0] RCA_ERR_MASK    = 16'hE000;
	localparam logic [9:0]  SCR_BLOCK_BYTES = 10'd8;
	localparam logic [27:0] WIDTH_4_BITS    = 28'd4;
	localparam logic [1:0]  CSD_VERSION_2   = 2'd1;

	// Configuration register indices and reset values.
	localparam logic CFG_ATTEMPT_LIMIT = 1'b0;
	localparam logic CFG_BUS_FREQ      = 1'b1;
	localparam logic [7:0]  ATTEMPT_LIMIT_RESET = 8'd10;
	localparam logic [27:0] BUS_FREQ_RESET      = 28'd25000000;

	// One input event.
	typedef struct packed {
		op_t         operation;
		logic        cmd_error;
		logic [31:0] resp_word0;
		logic [31:0] resp_word1;
		logic [31:0] resp_word2;
		logic [31:0] scr_word;
		logic        host_ok;
	} sdci_event_t;

	// Sequencer context carried from one event to the next.
	typedef struct packed {
		step_t       step;
		logic [7:0]  poll_attempts;
		logic [15:0] rca;
		logic [41:0] capacity;
		logic        lv_ok;
	} sdci_state_t;

	// Per-event action fields.
	typedef struct packed {
		action_t     action;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [9:0]  block_size;
		logic [27:0] host_value;
		fail_t       fail_code;
	} sdci_result_t;

endpackage

`default_nettype wire

/* rtl/sdci_step.sv */
// Next-step logic of the SD card initialization sequencer: one event in,
// the next context and the host action out. Depends on sdci_pkg.
`default_nettype none

module sdci_step (
	input  sdci_pkg::sdci_event_t  evt,
	input  sdci_pkg::sdci_state_t  cur,
	input  logic [7:0]             attempt_limit,
	input  logic [27:0]            bus_freq,
	output sdci_pkg::sdci_state_t  nxt,
	output sdci_pkg::sdci_result_t res
);

	logic [31:0] rca_arg;
	logic [31:0] new_rca_arg;
	logic [21:0] c_size;
	logic [41:0] capacity_calc;
	logic [7:0]  attempts_inc;
	logic        cmd_awaited;

	// Helper values derived from the current context and the event.
	assign rca_arg       = {cur.rca, 16'h0000};
	assign new_rca_arg   = {evt.resp_word0[31:16], 16'h0000};
	assign c_size        = {evt.resp_word1[5:0], evt.resp_word2[31:16]};
	assign capacity_calc = {(23'(c_size) + 23'd1), 19'd0};
	assign attempts_inc  = (cur.poll_attempts == 8'hFF) ? 8'hFF : cur.poll_attempts + 8'd1;

	// Steps that wait for a command completion.
	always_comb begin
		case (cur.step) inside
			[sdci_pkg::ST_CMD0 : sdci_pkg::ST_POLL],
			sdci_pkg::ST_VSW,
			[sdci_pkg::ST_CID : sdci_pkg::ST_BW]: cmd_awaited = 1'b1;
			default:                              cmd_awaited = 1'b0;
		endcase
	end

	// Sequence transition.
	always_comb begin
		nxt = cur;
		res = '0;
		unique case (evt.operation)
			sdci_pkg::OP_START: begin
				nxt.poll_attempts = '0;
				nxt.rca           = '0;
				nxt.capacity      = '0;
				nxt.lv_ok         = 1'b0;
				res.action        = sdci_pkg::ACT_ISSUE_CMD;
				res.cmd_index     = sdci_pkg::CMD_GO_IDLE;
				nxt.step          = sdci_pkg::ST_CMD0;
			end
			sdci_pkg::OP_CMD_DONE: begin
				if (cur.step == sdci_pkg::ST_APP_BW || cur.step == sdci_pkg::ST_BW) begin
					// Bus-width failures are not fatal: they end in done.
					if (evt.cmd_error) begin
						res.action = sdci_pkg::ACT_DONE;
						nxt.step   = sdci_pkg::ST_DONE;
					end else if (cur.step == sdci_pkg::ST_APP_BW) begin
						res.action    = sdci_pkg::ACT_ISSUE_CMD;
						res.cmd_index = sdci_pkg::ACMD_SET_BUS_WIDTH;
						res.cmd_arg   = sdci_pkg::BUS_WIDTH_4_ARG;
						nxt.step      = sdci_pkg::ST_BW;
					end else begin
						res.action     = sdci_pkg::ACT_SET_WIDTH;
						res.host_value = sdci_pkg::WIDTH_4_BITS;
						nxt.step       = sdci_pkg::ST_HOST_BW;
					end
				end else if (cmd_awaited && evt.cmd_error) begin
					res.action    = sdci_pkg::ACT_FAILED;
					res.fail_code = sdci_pkg::FAIL_CMD_ERROR;
					nxt.step      = sdci_pkg::ST_FAILED;
				end else begin
					unique case (cur.step)
						sdci_pkg::ST_CMD0: begin
							res.action    = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index = sdci_pkg::CMD_SEND_IF_COND;
							res.cmd_arg   = sdci_pkg::IF_COND_ARG;
							nxt.step      = sdci_pkg::ST_CMD8;
						end
						sdci_pkg::ST_CMD8: begin
							if (evt.resp_word0[11:0] != sdci_pkg::IF_COND_PATTERN) begin
								res.action    = sdci_pkg::ACT_FAILED;
								res.fail_code = sdci_pkg::FAIL_ECHO;
								nxt.step      = sdci_pkg::ST_FAILED;
							end else begin
								res.action    = sdci_pkg::ACT_ISSUE_CMD;
								res.cmd_index = sdci_pkg::CMD_APP_CMD;
								nxt.step      = sdci_pkg::ST_APP_INQ;
							end
						end
						sdci_pkg::ST_APP_INQ: begin
							res.action    = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index = sdci_pkg::ACMD_SD_SEND_OP;
							nxt.step      = sdci_pkg::ST_INQ;
						end
						sdci_pkg::ST_INQ: begin
							res.action    = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index = sdci_pkg::CMD_APP_CMD;
							nxt.step      = sdci_pkg::ST_APP_POLL;
						end
						sdci_pkg::ST_APP_POLL: begin
							res.action    = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index = sdci_pkg::ACMD_SD_SEND_OP;
							res.cmd_arg   = sdci_pkg::OP_COND_ARG;
							nxt.step      = sdci_pkg::ST_POLL;
						end
						sdci_pkg::ST_POLL: begin
							if (evt.resp_word0[31]) begin
								// Card is ready; it must report high capacity.
								if (!evt.resp_word0[30]) begin
									res.action    = sdci_pkg::ACT_FAILED;
									res.fail_code = sdci_pkg::FAIL_NOT_SDHC;
									nxt.step      = sdci_pkg::ST_FAILED;
								end else begin
									nxt.lv_ok      = evt.resp_word0[24];
									res.action     = sdci_pkg::ACT_SET_FREQ;
									res.host_value = bus_freq;
									nxt.step       = sdci_pkg::ST_FREQ;
								end
							end else begin
								// Still busy: count the attempt and wait or give up.
								nxt.poll_attempts = attempts_inc;
								if (attempts_inc >= attempt_limit) begin
									res.action    = sdci_pkg::ACT_FAILED;
									res.fail_code = sdci_pkg::FAIL_POLL_TIMEOUT;
									nxt.step      = sdci_pkg::ST_FAILED;
								end else begin
									res.action = sdci_pkg::ACT_WAIT;
									nxt.step   = sdci_pkg::ST_WAIT;
								end
							end
						end
						sdci_pkg::ST_VSW: begin
							res.action = sdci_pkg::ACT_SET_1V8;
							nxt.step   = sdci_pkg::ST_VOLT;
						end
						sdci_pkg::ST_CID: begin
							res.action    = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index = sdci_pkg::CMD_SEND_RCA;
							nxt.step      = sdci_pkg::ST_RCA;
						end
						sdci_pkg::ST_RCA: begin
							// The address is kept even when the status checks fail.
							nxt.rca = evt.resp_word0[31:16];
							if ((evt.resp_word0[15:0] & sdci_pkg::RCA_ERR_MASK) != 16'h0000) begin
								res.action    = sdci_pkg::ACT_FAILED;
								res.fail_code = sdci_pkg::FAIL_RCA_STATUS;
								nxt.step      = sdci_pkg::ST_FAILED;
							end else if (!evt.resp_word0[8]) begin
								res.action    = sdci_pkg::ACT_FAILED;
								res.fail_code = sdci_pkg::FAIL_NOT_READY;
								nxt.step      = sdci_pkg::ST_FAILED;
							end else begin
								res.action    = sdci_pkg::ACT_ISSUE_CMD;
								res.cmd_index = sdci_pkg::CMD_SEND_CSD;
								res.cmd_arg   = new_rca_arg;
								nxt.step      = sdci_pkg::ST_CSD;
							end
						end
						sdci_pkg::ST_CSD: begin
							if (evt.resp_word0[31:30] != sdci_pkg::CSD_VERSION_2) begin
								res.action    = sdci_pkg::ACT_FAILED;
								res.fail_code = sdci_pkg::FAIL_CSD_VERSION;
								nxt.step      = sdci_pkg::ST_FAILED;
							end else begin
								nxt.capacity  = capacity_calc;
								res.action    = sdci_pkg::ACT_ISSUE_CMD;
								res.cmd_index = sdci_pkg::CMD_SELECT;
								res.cmd_arg   = rca_arg;
								nxt.step      = sdci_pkg::ST_SEL;
							end
						end
						sdci_pkg::ST_SEL: begin
							res.action    = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index = sdci_pkg::CMD_APP_CMD;
							res.cmd_arg   = rca_arg;
							nxt.step      = sdci_pkg::ST_APP_SCR;
						end
						sdci_pkg::ST_APP_SCR: begin
							res.action     = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index  = sdci_pkg::ACMD_SEND_SCR;
							res.block_size = sdci_pkg::SCR_BLOCK_BYTES;
							nxt.step       = sdci_pkg::ST_SCR;
						end
						sdci_pkg::ST_SCR: begin
							// Go for the 4-bit bus only if the card lists it.
							if (evt.scr_word[18]) begin
								res.action    = sdci_pkg::ACT_ISSUE_CMD;
								res.cmd_index = sdci_pkg::CMD_APP_CMD;
								res.cmd_arg   = rca_arg;
								nxt.step      = sdci_pkg::ST_APP_BW;
							end else begin
								res.action = sdci_pkg::ACT_DONE;
								nxt.step   = sdci_pkg::ST_DONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			sdci_pkg::OP_HOST_DONE: begin
				unique case (cur.step)
					sdci_pkg::ST_FREQ: begin
						res.action = sdci_pkg::ACT_ISSUE_CMD;
						if (cur.lv_ok) begin
							res.cmd_index = sdci_pkg::CMD_VOLT_SWITCH;
							nxt.step      = sdci_pkg::ST_VSW;
						end else begin
							res.cmd_index = sdci_pkg::CMD_ALL_SEND_CID;
							nxt.step      = sdci_pkg::ST_CID;
						end
					end
					sdci_pkg::ST_VOLT: begin
						if (!evt.host_ok) begin
							res.action    = sdci_pkg::ACT_FAILED;
							res.fail_code = sdci_pkg::FAIL_VOLT;
							nxt.step      = sdci_pkg::ST_FAILED;
						end else begin
							res.action    = sdci_pkg::ACT_ISSUE_CMD;
							res.cmd_index = sdci_pkg::CMD_ALL_SEND_CID;
							nxt.step      = sdci_pkg::ST_CID;
						end
					end
					sdci_pkg::ST_HOST_BW: begin
						res.action = sdci_pkg::ACT_DONE;
						nxt.step   = sdci_pkg::ST_DONE;
					end
					default: begin
					end
				endcase
			end
			sdci_pkg::OP_POLL_DELAY: begin
				if (cur.step == sdci_pkg::ST_WAIT) begin
					res.action    = sdci_pkg::ACT_ISSUE_CMD;
					res.cmd_index = sdci_pkg::CMD_APP_CMD;
					nxt.step      = sdci_pkg::ST_APP_POLL;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/sd_card_init_sequencer.sv */
// An event passes through the input register, then the result register.
// Throughput: one event per cycle while the action channel does not stall;
// the sequencer context is updated when an event moves into the result
// register. Reset clears the context to the idle step, both channels to
// empty, and the attempt limit and bus frequency registers to 10 and 25 MHz.
// Top level; depends on sdci_pkg and sdci_step.
`default_nettype none

module sd_card_init_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [27:0] cfg_data,
	// Event channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic        cmd_error,
	input  logic [31:0] resp_word0,
	input  logic [31:0] resp_word1,
	input  logic [31:0] resp_word2,
	input  logic [31:0] scr_word,
	input  logic        host_ok,
	// Action channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [5:0]  cmd_index,
	output logic [31:0] cmd_arg,
	output logic [9:0]  data_block_size,
	output logic [27:0] host_value,
	output logic [3:0]  fail_code,
	output logic [15:0] card_rca,
	output logic [41:0] card_capacity,
	output logic        signalling_1v8
);

	logic [7:0]             attempt_limit_q;
	logic [27:0]            bus_freq_q;
	logic                   valid_s1;
	sdci_pkg::sdci_event_t  evt_s1;
	sdci_pkg::sdci_state_t  ctx_q;
	sdci_pkg::sdci_state_t  ctx_next;
	sdci_pkg::sdci_result_t res_next;
	sdci_pkg::sdci_result_t res_q;
	logic [15:0]            rca_q;
	logic [41:0]            capacity_q;
	logic                   lv_ok_q;
	logic                   out_valid_q;
	logic                   advance;
	logic                   in_take;

	// Handshake: the input stage moves on when the result register is free
	// or its transaction completes in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= sdci_pkg::ATTEMPT_LIMIT_RESET;
			bus_freq_q      <= sdci_pkg::BUS_FREQ_RESET;
		end else if (cfg_write) begin
			if (cfg_index == sdci_pkg::CFG_ATTEMPT_LIMIT) begin
				attempt_limit_q <= cfg_data[7:0];
			end else begin
				bus_freq_q <= cfg_data;
			end
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			evt_s1.operation  <= sdci_pkg::op_t'(operation);
			evt_s1.cmd_error  <= cmd_error;
			evt_s1.resp_word0 <= resp_word0;
			evt_s1.resp_word1 <= resp_word1;
			evt_s1.resp_word2 <= resp_word2;
			evt_s1.scr_word   <= scr_word;
			evt_s1.host_ok    <= host_ok;
		end
	end

	sdci_step u_step (
		.evt           (evt_s1),
		.cur           (ctx_q),
		.attempt_limit (attempt_limit_q),
		.bus_freq      (bus_freq_q),
		.nxt           (ctx_next),
		.res           (res_next)
	);

	// Sequencer context.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.step          <= sdci_pkg::ST_IDLE;
			ctx_q.poll_attempts <= '0;
			ctx_q.rca           <= '0;
			ctx_q.capacity      <= '0;
			ctx_q.lv_ok         <= 1'b0;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q      <= res_next;
			rca_q      <= ctx_next.rca;
			capacity_q <= ctx_next.capacity;
			lv_ok_q    <= ctx_next.lv_ok;
		end
	end

	assign out_valid       = out_valid_q;
	assign action          = res_q.action;
	assign cmd_index       = res_q.cmd_index;
	assign cmd_arg         = res_q.cmd_arg;
	assign data_block_size = res_q.block_size;
	assign host_value      = res_q.host_value;
	assign fail_code       = res_q.fail_code;
	assign card_rca        = rca_q;
	assign card_capacity   = capacity_q;
	assign signalling_1v8  = lv_ok_q;

	// A failure code is given exactly when the action is failed.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_q.action == sdci_pkg::ACT_FAILED) ==
			(res_q.fail_code != sdci_pkg::FAIL_NONE)))
		else $error("fail code does not match action");

	// Command fields stay zero unless a command is issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.action != sdci_pkg::ACT_ISSUE_CMD) |->
			(res_q.cmd_index == 6'd0 && res_q.cmd_arg == 32'd0))
		else $error("command fields set without a command");

	// The context changes only when an event moves into the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(ctx_q))
		else $error("context changed without an event");

	// An event leaving the input stage always lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("event lost between stages");

endmodule

`default_nettype wire
